// ----- hw/rtl/lob_pkg.sv -----
package lob_pkg;

    // request codes
    localparam logic [1:0] REQ_LIMIT  = 2'd0;
    localparam logic [1:0] REQ_MARKET = 2'd1;
    localparam logic [1:0] REQ_CANCEL = 2'd2;
    localparam logic [1:0] REQ_MODIFY = 2'd3;

    // result kinds
    localparam logic [2:0] KIND_TRADE   = 3'd0;
    localparam logic [2:0] KIND_OK      = 3'd1;
    localparam logic [2:0] KIND_DUP     = 3'd2;
    localparam logic [2:0] KIND_UNKNOWN = 3'd3;
    localparam logic [2:0] KIND_NO_ROOM = 3'd4;

    localparam int RANK_W  = 6;
    localparam int COUNT_W = 6;

    typedef enum logic [1:0] {
        SCAN_LOOK,
        SCAN_PICK,
        SCAN_TOP
    } t_scan;

    typedef struct packed {
        logic       load;
        logic       scan_clr;
        t_scan      scan_mode;
        logic       zero_qty;
        logic       drop_hit;
        logic       reduce_hit;
        logic       relimit;
        logic       fill;
        logic       rest;
        logic       final_out;
        logic [2:0] kind;
    } t_cmd;

    typedef struct packed {
        logic       scan_done;
        logic       hit;
        logic       best_ok;
        logic       qty_zero;
        logic       full;
        logic       same_reduce;
        logic [1:0] req_type;
        logic       tif;
    } t_sts;

endpackage

// ----- hw/rtl/lob_ctrl.sv -----
module lob_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  lob_pkg::t_sts i_sts,
    output lob_pkg::t_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOOK,
        S_DECIDE,
        S_PICK_GO,
        S_PICK,
        S_PICKED,
        S_FILL,
        S_REST,
        S_TOP_GO,
        S_TOP,
        S_FINAL
    } t_state;

    t_state     r_state, n_state;
    logic [2:0] r_kind, n_kind;
    logic       r_chk, n_chk;

    assign busy = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        n_kind  = r_kind;
        n_chk   = r_chk;
        o_cmd   = '0;
        o_cmd.scan_mode = lob_pkg::SCAN_LOOK;
        o_cmd.kind      = r_kind;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load     = 1'b1;
                    o_cmd.scan_clr = 1'b1;
                    n_chk          = 1'b0;
                    n_state        = S_LOOK;
                end
            end
            S_LOOK: begin
                if (i_sts.scan_done) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_kind = lob_pkg::KIND_OK;
                case (i_sts.req_type)
                    lob_pkg::REQ_LIMIT: begin
                        if (!i_sts.tif && i_sts.full && !i_sts.qty_zero) begin
                            n_chk   = 1'b1;
                            n_state = S_PICK_GO;
                        end else if (i_sts.hit) begin
                            n_kind  = lob_pkg::KIND_DUP;
                            n_state = S_TOP_GO;
                        end else begin
                            n_state = S_PICK_GO;
                        end
                    end
                    lob_pkg::REQ_MARKET: begin
                        if (i_sts.hit) begin
                            n_kind  = lob_pkg::KIND_DUP;
                            n_state = S_TOP_GO;
                        end else begin
                            n_state = S_PICK_GO;
                        end
                    end
                    lob_pkg::REQ_CANCEL: begin
                        o_cmd.zero_qty = 1'b1;
                        n_state        = S_TOP_GO;
                        if (i_sts.hit) begin
                            o_cmd.drop_hit = 1'b1;
                        end else begin
                            n_kind = lob_pkg::KIND_UNKNOWN;
                        end
                    end
                    default: begin
                        if (!i_sts.hit) begin
                            o_cmd.zero_qty = 1'b1;
                            n_kind         = lob_pkg::KIND_UNKNOWN;
                            n_state        = S_TOP_GO;
                        end else if (i_sts.qty_zero) begin
                            o_cmd.drop_hit = 1'b1;
                            n_state        = S_TOP_GO;
                        end else if (i_sts.same_reduce) begin
                            o_cmd.reduce_hit = 1'b1;
                            o_cmd.zero_qty   = 1'b1;
                            n_state          = S_TOP_GO;
                        end else begin
                            // pull the order and re-enter it as a GTC limit
                            o_cmd.drop_hit = 1'b1;
                            o_cmd.relimit  = 1'b1;
                            n_state        = S_PICK_GO;
                        end
                    end
                endcase
            end
            S_PICK_GO: begin
                if (i_sts.qty_zero) begin
                    n_state = S_REST;
                end else begin
                    o_cmd.scan_clr  = 1'b1;
                    o_cmd.scan_mode = lob_pkg::SCAN_PICK;
                    n_state         = S_PICK;
                end
            end
            S_PICK: begin
                o_cmd.scan_mode = lob_pkg::SCAN_PICK;
                if (i_sts.scan_done) begin
                    n_state = S_PICKED;
                end
            end
            S_PICKED: begin
                if (r_chk) begin
                    // full book: one crossing maker is enough to make room or fill
                    n_chk = 1'b0;
                    if (!i_sts.best_ok) begin
                        n_kind  = lob_pkg::KIND_NO_ROOM;
                        n_state = S_TOP_GO;
                    end else if (i_sts.hit) begin
                        n_kind  = lob_pkg::KIND_DUP;
                        n_state = S_TOP_GO;
                    end else begin
                        n_state = S_FILL;
                    end
                end else if (i_sts.best_ok) begin
                    n_state = S_FILL;
                end else begin
                    n_state = S_REST;
                end
            end
            S_FILL: begin
                o_cmd.fill = 1'b1;
                n_state    = S_PICK_GO;
            end
            S_REST: begin
                if (i_sts.req_type == lob_pkg::REQ_LIMIT && !i_sts.tif && !i_sts.qty_zero) begin
                    o_cmd.rest = 1'b1;
                end
                n_kind  = lob_pkg::KIND_OK;
                n_state = S_TOP_GO;
            end
            S_TOP_GO: begin
                o_cmd.scan_clr  = 1'b1;
                o_cmd.scan_mode = lob_pkg::SCAN_TOP;
                n_state         = S_TOP;
            end
            S_TOP: begin
                o_cmd.scan_mode = lob_pkg::SCAN_TOP;
                if (i_sts.scan_done) begin
                    n_state = S_FINAL;
                end
            end
            S_FINAL: begin
                o_cmd.final_out = 1'b1;
                n_state         = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_kind  <= lob_pkg::KIND_OK;
            r_chk   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_kind  <= n_kind;
            r_chk   <= n_chk;
        end
    end

endmodule

// ----- hw/rtl/lob_datapath.sv -----
module lob_datapath #(
    parameter int ORDER_SLOTS = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  lob_pkg::t_cmd i_cmd,
    output lob_pkg::t_sts o_sts,
    input  logic [1:0]    i_req_type,
    input  logic [31:0]   i_order_id,
    input  logic          i_side,
    input  logic [31:0]   i_price,
    input  logic [31:0]   i_quantity,
    input  logic          i_tif,
    output logic          o_strobe,
    output logic [2:0]    o_result_kind,
    output logic [31:0]   o_filled_id,
    output logic [31:0]   o_fill_price,
    output logic [31:0]   o_fill_qty,
    output logic [31:0]   o_remainder,
    output logic          o_rested,
    output logic          o_bid_valid,
    output logic [31:0]   o_bid_price,
    output logic          o_ask_valid,
    output logic [31:0]   o_ask_price,
    output logic [5:0]    o_resting_count,
    output logic          o_last
);

    localparam int IW = (ORDER_SLOTS > 1) ? $clog2(ORDER_SLOTS) : 1;
    localparam int CW = $clog2(ORDER_SLOTS + 1);
    localparam int RW = lob_pkg::RANK_W;

    // slot store
    logic              r_valid [ORDER_SLOTS];
    logic [31:0]       r_sid   [ORDER_SLOTS];
    logic              r_sside [ORDER_SLOTS];
    logic [31:0]       r_sprice[ORDER_SLOTS];
    logic [31:0]       r_sqty  [ORDER_SLOTS];
    logic [RW-1:0]     r_srank [ORDER_SLOTS];
    logic [CW-1:0]     r_count;

    // request
    logic [1:0]        r_type;
    logic [31:0]       r_id;
    logic              r_side;
    logic [31:0]       r_price;
    logic [31:0]       r_qty;
    logic              r_tif;
    logic              r_mkt;
    logic              r_rested;

    // scan pipe
    lob_pkg::t_scan    r_mode;
    logic              r_issuing;
    logic [IW-1:0]     r_idx;
    logic              r_pv;
    logic [IW-1:0]     r_pidx;
    logic [31:0]       r_rd_id;
    logic              r_rd_side;
    logic [31:0]       r_rd_price;
    logic [31:0]       r_rd_qty;

    // lookup capture
    logic              r_hit;
    logic [IW-1:0]     r_hidx;
    logic              r_hside;
    logic [31:0]       r_hprice;
    logic [31:0]       r_hqty;
    logic [RW-1:0]     r_hrank;
    logic [IW-1:0]     r_free;

    // best maker capture
    logic              r_best_ok;
    logic [IW-1:0]     r_bidx;
    logic [31:0]       r_bid_id;
    logic [31:0]       r_bprice;
    logic [31:0]       r_bqty;
    logic [RW-1:0]     r_brank;

    // book top
    logic              r_bid_v;
    logic [31:0]       r_bid;
    logic              r_ask_v;
    logic [31:0]       r_ask;

    logic              p_valid;
    logic [RW-1:0]     p_rank;
    logic              elig;
    logic              better;
    logic [31:0]       fill_t;
    logic              drop;
    logic [IW-1:0]     drop_idx;
    logic [RW-1:0]     drop_rank;

    assign p_valid = r_valid[r_pidx];
    assign p_rank  = r_srank[r_pidx];

    always_comb begin
        elig = p_valid && (r_rd_side != r_side) &&
               (r_mkt || (r_side ? (r_rd_price >= r_price) : (r_rd_price <= r_price)));
        if (!r_best_ok) begin
            better = 1'b1;
        end else if (r_rd_price != r_bprice) begin
            better = r_side ? (r_rd_price > r_bprice) : (r_rd_price < r_bprice);
        end else begin
            better = p_rank < r_brank;
        end
    end

    assign fill_t    = (r_qty < r_bqty) ? r_qty : r_bqty;
    assign drop      = i_cmd.drop_hit || (i_cmd.fill && (r_bqty <= r_qty));
    assign drop_idx  = i_cmd.drop_hit ? r_hidx : r_bidx;
    assign drop_rank = i_cmd.drop_hit ? r_hrank : r_brank;

    assign o_sts.scan_done   = r_pv && (r_pidx == IW'(ORDER_SLOTS - 1));
    assign o_sts.hit         = r_hit;
    assign o_sts.best_ok     = r_best_ok;
    assign o_sts.qty_zero    = (r_qty == 32'd0);
    assign o_sts.full        = (r_count == CW'(ORDER_SLOTS));
    assign o_sts.same_reduce = (r_price == r_hprice) && (r_qty <= r_hqty);
    assign o_sts.req_type    = r_type;
    assign o_sts.tif         = r_tif;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ORDER_SLOTS; i++) begin
                r_valid[i] <= 1'b0;
            end
            r_count   <= '0;
            r_issuing <= 1'b0;
            r_pv      <= 1'b0;
            o_strobe  <= 1'b0;
        end else begin
            o_strobe <= i_cmd.fill || i_cmd.final_out;
            r_pv     <= r_issuing;
            if (i_cmd.scan_clr) begin
                r_issuing <= 1'b1;
            end else if (r_issuing && (r_idx == IW'(ORDER_SLOTS - 1))) begin
                r_issuing <= 1'b0;
            end
            if (drop) begin
                r_valid[drop_idx] <= 1'b0;
                r_count           <= r_count - CW'(1);
            end else if (i_cmd.rest) begin
                r_valid[r_free] <= 1'b1;
                r_count         <= r_count + CW'(1);
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_type   <= i_req_type;
            r_id     <= i_order_id;
            r_side   <= i_side;
            r_price  <= i_price;
            r_qty    <= i_quantity;
            r_tif    <= i_tif;
            r_mkt    <= (i_req_type == lob_pkg::REQ_MARKET);
            r_rested <= 1'b0;
        end

        // registered read, one slot a cycle
        if (i_cmd.scan_clr) begin
            r_idx  <= '0;
            r_mode <= i_cmd.scan_mode;
            case (i_cmd.scan_mode)
                lob_pkg::SCAN_LOOK: r_hit <= 1'b0;
                lob_pkg::SCAN_PICK: r_best_ok <= 1'b0;
                default: begin
                    r_bid_v <= 1'b0;
                    r_bid   <= '0;
                    r_ask_v <= 1'b0;
                    r_ask   <= '0;
                end
            endcase
        end else if (r_issuing) begin
            r_idx <= r_idx + IW'(1);
        end
        if (r_issuing) begin
            r_rd_id    <= r_sid[r_idx];
            r_rd_side  <= r_sside[r_idx];
            r_rd_price <= r_sprice[r_idx];
            r_rd_qty   <= r_sqty[r_idx];
            r_pidx     <= r_idx;
        end

        if (r_pv) begin
            case (r_mode)
                lob_pkg::SCAN_LOOK: begin
                    if (p_valid && (r_rd_id == r_id)) begin
                        r_hit    <= 1'b1;
                        r_hidx   <= r_pidx;
                        r_hside  <= r_rd_side;
                        r_hprice <= r_rd_price;
                        r_hqty   <= r_rd_qty;
                        r_hrank  <= p_rank;
                    end
                    if (!p_valid) begin
                        r_free <= r_pidx;
                    end
                end
                lob_pkg::SCAN_PICK: begin
                    if (elig && better) begin
                        r_best_ok <= 1'b1;
                        r_bidx    <= r_pidx;
                        r_bid_id  <= r_rd_id;
                        r_bprice  <= r_rd_price;
                        r_bqty    <= r_rd_qty;
                        r_brank   <= p_rank;
                    end
                end
                default: begin
                    if (p_valid && !r_rd_side && (!r_bid_v || r_rd_price > r_bid)) begin
                        r_bid_v <= 1'b1;
                        r_bid   <= r_rd_price;
                    end
                    if (p_valid && r_rd_side && (!r_ask_v || r_rd_price < r_ask)) begin
                        r_ask_v <= 1'b1;
                        r_ask   <= r_rd_price;
                    end
                end
            endcase
        end

        if (i_cmd.zero_qty) begin
            r_qty <= '0;
        end
        if (i_cmd.reduce_hit) begin
            r_sqty[r_hidx] <= r_qty;
        end
        if (i_cmd.relimit) begin
            r_side <= r_hside;
            r_tif  <= 1'b0;
            r_type <= lob_pkg::REQ_LIMIT;
            r_mkt  <= 1'b0;
        end

        // removal closes the gap in arrival ranks
        if (drop) begin
            for (int i = 0; i < ORDER_SLOTS; i++) begin
                if (r_valid[i] && (r_srank[i] > drop_rank)) begin
                    r_srank[i] <= r_srank[i] - RW'(1);
                end
            end
            r_free <= drop_idx;
        end

        if (i_cmd.fill) begin
            r_qty          <= r_qty - fill_t;
            r_sqty[r_bidx] <= r_bqty - fill_t;
            o_result_kind   <= lob_pkg::KIND_TRADE;
            o_filled_id     <= r_bid_id;
            o_fill_price    <= r_bprice;
            o_fill_qty      <= fill_t;
            o_remainder     <= '0;
            o_rested        <= 1'b0;
            o_bid_valid     <= 1'b0;
            o_bid_price     <= '0;
            o_ask_valid     <= 1'b0;
            o_ask_price     <= '0;
            o_resting_count <= '0;
            o_last          <= 1'b0;
        end

        if (i_cmd.rest) begin
            r_sid[r_free]    <= r_id;
            r_sside[r_free]  <= r_side;
            r_sprice[r_free] <= r_price;
            r_sqty[r_free]   <= r_qty;
            r_srank[r_free]  <= RW'(r_count);
            r_rested         <= 1'b1;
        end

        if (i_cmd.final_out) begin
            o_result_kind   <= i_cmd.kind;
            o_filled_id     <= '0;
            o_fill_price    <= '0;
            o_fill_qty      <= '0;
            o_remainder     <= r_qty;
            o_rested        <= r_rested;
            o_bid_valid     <= r_bid_v;
            o_bid_price     <= r_bid;
            o_ask_valid     <= r_ask_v;
            o_ask_price     <= r_ask;
            o_resting_count <= lob_pkg::COUNT_W'(r_count);
            o_last          <= 1'b1;
        end
    end

endmodule

// ----- hw/rtl/limit_order_book_matcher_unit.sv -----
// A cancel, a modify that reduces or cancels, an unknown id or a duplicate puts its one word
//   out after the id lookup and book-top scans; a limit or market order adds a best-maker
//   pick scan and a trade word per fill (a full-book refusal runs one pick and no fill).
// Throughput: one request at a time, set by the one-slot-a-cycle scans (id lookup, one
//   best-maker pick per fill, book top); busy drops as the final word goes out.
// Results are single-cycle strobes, the receiver cannot stall; synchronous reset empties the book.
module limit_order_book_matcher_unit #(
    parameter int ORDER_SLOTS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_req_type,
    input  logic [31:0] i_order_id,
    input  logic        i_side,
    input  logic [31:0] i_price,
    input  logic [31:0] i_quantity,
    input  logic        i_tif,
    output logic        o_strobe,
    output logic [2:0]  o_result_kind,
    output logic [31:0] o_filled_id,
    output logic [31:0] o_fill_price,
    output logic [31:0] o_fill_qty,
    output logic [31:0] o_remainder,
    output logic        o_rested,
    output logic        o_bid_valid,
    output logic [31:0] o_bid_price,
    output logic        o_ask_valid,
    output logic [31:0] o_ask_price,
    output logic [5:0]  o_resting_count,
    output logic        o_last
);

    // Controller sequences the scans: id lookup, then a decision on the
    // request kind, then pick/fill rounds (one trade word per fill), the
    // rest of a GTC remainder, and a final book-top scan before the last word.
    lob_pkg::t_cmd cmd;
    lob_pkg::t_sts sts;

    lob_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // Datapath owns the slot store; arrival ranks stay dense (0..count-1),
    // so a removal decrements every younger rank as the slot is cleared.
    lob_datapath #(
        .ORDER_SLOTS (ORDER_SLOTS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_req_type      (i_req_type),
        .i_order_id      (i_order_id),
        .i_side          (i_side),
        .i_price         (i_price),
        .i_quantity      (i_quantity),
        .i_tif           (i_tif),
        .o_strobe        (o_strobe),
        .o_result_kind   (o_result_kind),
        .o_filled_id     (o_filled_id),
        .o_fill_price    (o_fill_price),
        .o_fill_qty      (o_fill_qty),
        .o_remainder     (o_remainder),
        .o_rested        (o_rested),
        .o_bid_valid     (o_bid_valid),
        .o_bid_price     (o_bid_price),
        .o_ask_valid     (o_ask_valid),
        .o_ask_price     (o_ask_price),
        .o_resting_count (o_resting_count),
        .o_last          (o_last)
    );

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps

module testbench;

    localparam int SLOTS       = 32;
    localparam int CYCLE_LIMIT = 1000000;

    // one result word as seen on the output ports
    typedef struct {
        logic [2:0]  kind;
        logic [31:0] filled_id;
        logic [31:0] fill_price;
        logic [31:0] fill_qty;
        logic [31:0] remainder;
        logic        rested;
        logic        bid_valid;
        logic [31:0] bid_price;
        logic        ask_valid;
        logic [31:0] ask_price;
        logic [5:0]  resting_count;
        logic        last;
    } t_book_word;

    // Book predictor plus expected-word queue.
    class book_scoreboard;
        bit        vld [SLOTS];
        bit [31:0] oid [SLOTS];
        bit        sd  [SLOTS];
        bit [31:0] px  [SLOTS];
        bit [31:0] qy  [SLOTS];
        bit [5:0]  rk  [SLOTS];
        t_book_word expected_words[$];

        function int live();
            int n;
            n = 0;
            foreach (vld[i]) if (vld[i]) n++;
            return n;
        endfunction

        function int find(bit [31:0] id);
            foreach (vld[i]) if (vld[i] && oid[i] == id) return i;
            return -1;
        endfunction

        // removal closes the gap in arrival ranks
        function void drop(int s);
            vld[s] = 0;
            foreach (vld[i]) if (vld[i] && rk[i] > rk[s]) rk[i]--;
        endfunction

        function int pick(bit lv[SLOTS], bit ts, bit mkt, bit [31:0] lim);
            int best;
            bit ok;
            best = -1;
            foreach (lv[i]) begin
                if (!lv[i] || sd[i] == ts) continue;
                ok = mkt || (ts == 1'b0 ? px[i] <= lim : px[i] >= lim);
                if (!ok) continue;
                if (best < 0) best = i;
                else if (px[i] != px[best]) begin
                    if (ts == 1'b0 ? px[i] < px[best] : px[i] > px[best]) best = i;
                end else if (rk[i] < rk[best]) begin
                    best = i;
                end
            end
            return best;
        endfunction

        function void push_trade(bit [31:0] id, bit [31:0] p, bit [31:0] q);
            t_book_word w;
            w = '{default: '0};
            w.kind = lob_pkg::KIND_TRADE;
            w.filled_id = id;
            w.fill_price = p;
            w.fill_qty = q;
            expected_words = {expected_words, w};
        endfunction

        function void push_final(logic [2:0] kind, bit [31:0] rem, bit rested);
            t_book_word w;
            w = '{default: '0};
            w.kind = kind;
            w.remainder = rem;
            w.rested = rested;
            foreach (vld[i]) begin
                if (!vld[i]) continue;
                if (sd[i] == 1'b0) begin
                    if (!w.bid_valid || px[i] > w.bid_price) w.bid_price = px[i];
                    w.bid_valid = 1'b1;
                end else begin
                    if (!w.ask_valid || px[i] < w.ask_price) w.ask_price = px[i];
                    w.ask_valid = 1'b1;
                end
            end
            w.resting_count = 6'(live());
            w.last = 1'b1;
            expected_words = {expected_words, w};
        endfunction

        function bit [31:0] sweep(bit ts, bit mkt, bit [31:0] lim, bit [31:0] qty);
            int m;
            bit [31:0] t;
            while (qty > 0) begin
                m = pick(vld, ts, mkt, lim);
                if (m < 0) break;
                t = qty < qy[m] ? qty : qy[m];
                push_trade(oid[m], px[m], t);
                qty -= t;
                qy[m] -= t;
                if (qy[m] == 0) drop(m);
            end
            return qty;
        endfunction

        // dry run on a full book: room only if filled or a maker is freed
        function bit room_when_full(bit ts, bit [31:0] lim, bit [31:0] qty);
            bit        lv [SLOTS];
            bit [31:0] q  [SLOTS];
            int m, freed;
            bit [31:0] t;
            lv = vld;
            q = qy;
            freed = 0;
            while (qty > 0) begin
                m = pick(lv, ts, 1'b0, lim);
                if (m < 0) break;
                t = qty < q[m] ? qty : q[m];
                qty -= t;
                q[m] -= t;
                if (q[m] == 0) begin
                    lv[m] = 0;
                    freed++;
                end
            end
            return qty == 0 || freed > 0;
        endfunction

        function void limit_order(bit [31:0] id, bit side, bit [31:0] price,
                                  bit [31:0] qty, bit tif);
            bit [31:0] rem;
            bit rested;
            rested = 0;
            if (!tif && live() >= SLOTS && !room_when_full(side, price, qty)) begin
                push_final(lob_pkg::KIND_NO_ROOM, qty, 0);
                return;
            end
            if (find(id) >= 0) begin
                push_final(lob_pkg::KIND_DUP, qty, 0);
                return;
            end
            rem = sweep(side, 1'b0, price, qty);
            if (!tif && rem > 0) begin
                foreach (vld[i]) begin
                    if (vld[i]) continue;
                    rk[i] = 6'(live());
                    vld[i] = 1;
                    oid[i] = id;
                    sd[i] = side;
                    px[i] = price;
                    qy[i] = rem;
                    rested = 1;
                    break;
                end
            end
            push_final(lob_pkg::KIND_OK, rem, rested);
        endfunction

        function void note_request(logic [1:0] rt, bit [31:0] id, bit side,
                                   bit [31:0] price, bit [31:0] qty, bit tif);
            int s;
            bit [31:0] rem;
            case (rt)
                lob_pkg::REQ_LIMIT: limit_order(id, side, price, qty, tif);
                lob_pkg::REQ_MARKET: begin
                    if (find(id) >= 0) push_final(lob_pkg::KIND_DUP, qty, 0);
                    else begin
                        rem = sweep(side, 1'b1, '0, qty);
                        push_final(lob_pkg::KIND_OK, rem, 0);
                    end
                end
                lob_pkg::REQ_CANCEL: begin
                    s = find(id);
                    if (s < 0) push_final(lob_pkg::KIND_UNKNOWN, 0, 0);
                    else begin
                        drop(s);
                        push_final(lob_pkg::KIND_OK, 0, 0);
                    end
                end
                default: begin
                    s = find(id);
                    if (s < 0) push_final(lob_pkg::KIND_UNKNOWN, 0, 0);
                    else if (qty == 0) begin
                        drop(s);
                        push_final(lob_pkg::KIND_OK, 0, 0);
                    end else if (price == px[s] && qty <= qy[s]) begin
                        qy[s] = qty;   // reduce in place, keeps priority
                        push_final(lob_pkg::KIND_OK, 0, 0);
                    end else begin
                        side = sd[s];
                        drop(s);
                        limit_order(id, side, price, qty, 1'b0);
                    end
                end
            endcase
        endfunction

        // empty string when the word matches the oldest expectation
        function string check_word(t_book_word got);
            t_book_word w;
            string diffs;
            if (expected_words.size() == 0) return "word with nothing expected";
            w = expected_words[0];
            expected_words.delete(0);
            diffs = "";
            if (got.kind !== w.kind) diffs = {diffs, $sformatf(" kind %0d/%0d", got.kind, w.kind)};
            if (got.filled_id !== w.filled_id)
                diffs = {diffs, $sformatf(" maker %0h/%0h", got.filled_id, w.filled_id)};
            if (got.fill_price !== w.fill_price)
                diffs = {diffs, $sformatf(" fprice %0h/%0h", got.fill_price, w.fill_price)};
            if (got.fill_qty !== w.fill_qty)
                diffs = {diffs, $sformatf(" fqty %0h/%0h", got.fill_qty, w.fill_qty)};
            if (got.remainder !== w.remainder)
                diffs = {diffs, $sformatf(" rem %0h/%0h", got.remainder, w.remainder)};
            if (got.rested !== w.rested) diffs = {diffs, " rested"};
            if (got.bid_valid !== w.bid_valid) diffs = {diffs, " bid_valid"};
            if (got.bid_price !== w.bid_price)
                diffs = {diffs, $sformatf(" bid %0h/%0h", got.bid_price, w.bid_price)};
            if (got.ask_valid !== w.ask_valid) diffs = {diffs, " ask_valid"};
            if (got.ask_price !== w.ask_price)
                diffs = {diffs, $sformatf(" ask %0h/%0h", got.ask_price, w.ask_price)};
            if (got.resting_count !== w.resting_count)
                diffs = {diffs, $sformatf(" count %0d/%0d", got.resting_count, w.resting_count)};
            if (got.last !== w.last) diffs = {diffs, " last"};
            return diffs;
        endfunction

        // some resting order, for well-formed cancels and modifies
        function bit any_resting(output bit [31:0] id, output bit [31:0] p,
                                 output bit [31:0] q);
            int s;
            if (live() == 0) return 0;
            do s = $urandom_range(SLOTS - 1); while (!vld[s]);
            id = oid[s];
            p = px[s];
            q = qy[s];
            return 1;
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_req_type;
    logic [31:0] i_order_id;
    logic        i_side;
    logic [31:0] i_price;
    logic [31:0] i_quantity;
    logic        i_tif;
    logic        o_strobe;
    logic [2:0]  o_result_kind;
    logic [31:0] o_filled_id;
    logic [31:0] o_fill_price;
    logic [31:0] o_fill_qty;
    logic [31:0] o_remainder;
    logic        o_rested;
    logic        o_bid_valid;
    logic [31:0] o_bid_price;
    logic        o_ask_valid;
    logic [31:0] o_ask_price;
    logic [5:0]  o_resting_count;
    logic        o_last;

    limit_order_book_matcher_unit #(.ORDER_SLOTS(SLOTS)) DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_req_type(i_req_type), .i_order_id(i_order_id), .i_side(i_side),
        .i_price(i_price), .i_quantity(i_quantity), .i_tif(i_tif),
        .o_strobe(o_strobe), .o_result_kind(o_result_kind), .o_filled_id(o_filled_id),
        .o_fill_price(o_fill_price), .o_fill_qty(o_fill_qty), .o_remainder(o_remainder),
        .o_rested(o_rested), .o_bid_valid(o_bid_valid), .o_bid_price(o_bid_price),
        .o_ask_valid(o_ask_valid), .o_ask_price(o_ask_price),
        .o_resting_count(o_resting_count), .o_last(o_last)
    );

    book_scoreboard book_sb;
    int errors;
    int cycles;
    bit [31:0] id_pool[24];

    // 10 ns clock
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    task automatic report(string msg);
        $display("MISMATCH at cycle %0d:%s", cycles, msg);
        errors++;
    endtask

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            report(" timeout");
            $display("Verification failed");
            $finish;
        end
    end

    // result side: the receiver cannot stall, every strobed word is checked
    always @(posedge i_clk) begin
        t_book_word got;
        string diffs;
        if (i_rst_n && o_strobe) begin
            got.kind = o_result_kind;
            got.filled_id = o_filled_id;
            got.fill_price = o_fill_price;
            got.fill_qty = o_fill_qty;
            got.remainder = o_remainder;
            got.rested = o_rested;
            got.bid_valid = o_bid_valid;
            got.bid_price = o_bid_price;
            got.ask_valid = o_ask_valid;
            got.ask_price = o_ask_price;
            got.resting_count = o_resting_count;
            got.last = o_last;
            diffs = book_sb.check_word(got);
            if (diffs != "") report(diffs);
        end
    end

    // mostly short gaps, now and then a long one
    task automatic idle_gap();
        int n;
        n = ($urandom_range(9) == 0) ? $urandom_range(250, 20) : $urandom_range(2);
        repeat (n) @(negedge i_clk);
    endtask

    // present one request word at the falling edge, hold until accepted
    task automatic send_request(logic [1:0] rt, bit [31:0] id, bit side,
                                bit [31:0] price, bit [31:0] qty, bit tif);
        idle_gap();
        @(negedge i_clk);
        start <= 1'b1;
        i_req_type <= rt;
        i_order_id <= id;
        i_side <= side;
        i_price <= price;
        i_quantity <= qty;
        i_tif <= tif;
        forever begin
            @(posedge i_clk);
            if (!busy) break;
        end
        book_sb.note_request(rt, id, side, price, qty, tif);
        @(negedge i_clk);
        start <= 1'b0;
        i_req_type <= 2'($urandom);
        i_order_id <= $urandom;
        i_price <= $urandom;
        i_quantity <= $urandom;
    endtask

    function automatic bit [31:0] pick_id();
        if ($urandom_range(9) < 7) return id_pool[$urandom_range(23)];
        return $urandom;
    endfunction

    function automatic bit [31:0] pick_price();
        case ($urandom_range(19))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom;
            default: return $urandom_range(110, 100);
        endcase
    endfunction

    function automatic bit [31:0] pick_qty();
        case ($urandom_range(29))
            0: return 32'd0;
            1, 2: return $urandom;
            default: return $urandom_range(20, 1);
        endcase
    endfunction

    // fill the book to the last slot, then probe the full-store rules
    task automatic fill_book();
        while (book_sb.live() < SLOTS)
            send_request(lob_pkg::REQ_LIMIT, $urandom, 1'b0, $urandom_range(60, 40),
                         $urandom_range(5, 1), 1'b0);
        send_request(lob_pkg::REQ_LIMIT, $urandom, 1'b0, 32'd50, 32'd3, 1'b0);     // refused
        send_request(lob_pkg::REQ_LIMIT, $urandom, 1'b1, 32'd70, 32'd3, 1'b0);     // refused
        send_request(lob_pkg::REQ_LIMIT, $urandom, 1'b1, 32'd0, 32'd1, 1'b0);      // fully fills
        send_request(lob_pkg::REQ_LIMIT, $urandom, 1'b1, 32'd45, 32'hFFFF, 1'b0);  // frees makers
        send_request(lob_pkg::REQ_MARKET, $urandom, 1'b1, 32'd0, 32'hFFFF_FFFF, 1'b0);
    endtask

    task automatic random_request();
        int sel;
        bit [31:0] id, p, q;
        sel = $urandom_range(99);
        if (sel < 45)
            send_request(lob_pkg::REQ_LIMIT, pick_id(), 1'($urandom), pick_price(),
                         pick_qty(), $urandom_range(3) == 0);
        else if (sel < 58)
            send_request(lob_pkg::REQ_MARKET, pick_id(), 1'($urandom), $urandom, pick_qty(),
                         1'($urandom));
        else if (sel < 75) begin
            if (!book_sb.any_resting(id, p, q) || $urandom_range(3) == 0) id = pick_id();
            send_request(lob_pkg::REQ_CANCEL, id, 1'($urandom), $urandom, $urandom,
                         1'($urandom));
        end else begin
            if (book_sb.any_resting(id, p, q) && $urandom_range(4) != 0) begin
                // half the time reduce in place, otherwise reprice or grow
                if ($urandom_range(1)) q = $urandom_range(q, (q > 1) ? 1 : q);
                else begin
                    p = pick_price();
                    q = pick_qty();
                end
            end else begin
                id = pick_id();
                p = pick_price();
                q = pick_qty();
            end
            send_request(lob_pkg::REQ_MODIFY, id, 1'($urandom), p, q, 1'($urandom));
        end
    endtask

    initial begin
        book_sb = new();
        errors = 0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_req_type = lob_pkg::REQ_LIMIT;
        i_order_id = '0;
        i_side = 1'b0;
        i_price = '0;
        i_quantity = '0;
        i_tif = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: each request kind and the named corner cases
        send_request(lob_pkg::REQ_LIMIT, 32'd1, 1'b0, 32'd100, 32'd10, 1'b0);      // rests
        send_request(lob_pkg::REQ_LIMIT, 32'd1, 1'b0, 32'd100, 32'd10, 1'b0);      // duplicate
        send_request(lob_pkg::REQ_LIMIT, 32'd2, 1'b1, 32'hFFFF_FFFF, 32'd5, 1'b0);
        send_request(lob_pkg::REQ_LIMIT, 32'd3, 1'b1, 32'd99, 32'd4, 1'b1);        // IOC fill
        send_request(lob_pkg::REQ_MARKET, 32'd4, 1'b1, 32'd0, 32'd100, 1'b0);      // drops rest
        send_request(lob_pkg::REQ_MARKET, 32'd5, 1'b0, 32'd0, 32'd2, 1'b1);
        send_request(lob_pkg::REQ_MARKET, 32'd2, 1'b0, 32'd0, 32'd1, 1'b0);        // dup market
        send_request(lob_pkg::REQ_CANCEL, 32'd2, 1'b0, 32'd0, 32'd0, 1'b0);
        send_request(lob_pkg::REQ_CANCEL, 32'd2, 1'b0, 32'd0, 32'd0, 1'b0);        // unknown
        send_request(lob_pkg::REQ_LIMIT, 32'd8, 1'b0, 32'd100, 32'd0, 1'b0);       // zero qty
        send_request(lob_pkg::REQ_MARKET, 32'd9, 1'b1, 32'd0, 32'd0, 1'b0);
        send_request(lob_pkg::REQ_LIMIT, 32'd6, 1'b0, 32'd0, 32'hFFFF_FFFF, 1'b0);
        send_request(lob_pkg::REQ_MODIFY, 32'd6, 1'b1, 32'd0, 32'd7, 1'b1);        // reduce
        send_request(lob_pkg::REQ_MODIFY, 32'd6, 1'b0, 32'd0, 32'd0, 1'b0);        // to zero
        send_request(lob_pkg::REQ_LIMIT, 32'd7, 1'b1, 32'd50, 32'd3, 1'b0);
        send_request(lob_pkg::REQ_MODIFY, 32'd7, 1'b0, 32'd40, 32'd3, 1'b0);       // reprice
        send_request(lob_pkg::REQ_MODIFY, 32'd77, 1'b0, 32'd40, 32'd3, 1'b0);      // unknown
        send_request(lob_pkg::REQ_LIMIT, 32'hFFFF_FFFF, 1'b0, 32'd60, 32'd8, 1'b0); // crosses
        send_request(lob_pkg::REQ_MODIFY, 32'hFFFF_FFFF, 1'b1, 32'd60, 32'd9, 1'b0); // grows
        send_request(lob_pkg::REQ_LIMIT, 32'hA5A5_5A5A, 1'b1, 32'd0, 32'hFFFF_FFFF, 1'b1);
        send_request(lob_pkg::REQ_MARKET, 32'h5A5A_A5A5, 1'b0, 32'hFFFF_FFFF,
                     32'hFFFF_FFFF, 1'b1);

        for (int i = 0; i < 24; i++) id_pool[i] = (i < 8) ? 32'(i) : $urandom;

        fill_book();
        repeat (55) random_request();

        while (book_sb.expected_words.size() != 0) @(posedge i_clk);
        repeat (4 * SLOTS + 20) @(posedge i_clk);
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
